// ----- hw/rtl/rc4_pkg.sv -----
package rc4_pkg;

    localparam int unsigned PERM_DEPTH = 256;

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_SCHED = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_D_J,
        S_D_T,
        S_D_OUT,
        S_K_RD,
        S_K_MIX,
        S_K_WA,
        S_K_WB
    } rc4_state_t;

endpackage

// ----- hw/rtl/rc4_stream_cipher_core.sv -----
// RC4 stream cipher core.
// Input channel (in_valid/in_ready) carries one command per transaction:
//   mode 0 writes key_byte at key_index into the key store,
//   mode 1 schedules over the first key_length (1..MAX_KEY_BYTES) key bytes,
//   mode 2 encrypts/decrypts data_byte and returns one result transaction,
//   mode 3 is dropped.
// Output channel (out_valid/out_ready) carries data_out and last_out.
// key_length is written via key_length_we while idle; the user must ensure it.
// A data byte issues its first read at acceptance, then steps through
// S_D_J, S_D_T and S_D_OUT: three dependent permutation reads plus two swap
// writes through the one write port of the permutation RAM; S_D_OUT loads
// the result into the output register. The key schedule runs S_K_RD, S_K_MIX,
// S_K_WA and S_K_WB per entry (same port limit); in_ready is low meanwhile.
// Reset clears the indices and marks every permutation entry as its own
// index through per-entry valid bits, so no clearing pass is needed; the
// key schedule start reloads the identity the same way.
// A stalled receiver holds the result in the output register; the core
// still accepts the next command, and a following data byte waits for the
// output register to free before it starts its swap.
module rc4_stream_cipher_core #(
    parameter int unsigned MAX_KEY_BYTES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] key_index,
    input  logic [7:0] key_byte,
    input  logic [7:0] data_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out,
    output logic       last_out,
    input  logic       key_length_we,
    input  logic [8:0] key_length
);
    import rc4_pkg::*;

    localparam int unsigned KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [8:0] MAX_LEN = 9'(MAX_KEY_BYTES);

    rc4_state_t state_reg, state_next;

    logic [7:0]        i_reg, j_reg, n_reg, acc_reg;
    logic [KEY_AW-1:0] pos_reg;
    logic              out_valid_reg;
    logic [8:0]        key_length_reg;
    logic [PERM_DEPTH-1:0] perm_vld_reg;

    logic [7:0] si_reg, sj_reg, t_reg;
    logic [7:0] data_hold_reg;
    logic       last_hold_reg;
    logic [7:0] data_out_reg;
    logic       last_out_reg;

    // permutation RAM and its read side
    logic [7:0] perm_mem [PERM_DEPTH];
    logic [7:0] perm_rd_mem_reg, perm_rd_addr_reg;
    logic       perm_rd_vld_reg;
    logic [7:0] perm_rd;

    logic [7:0] key_mem [MAX_KEY_BYTES];
    logic [7:0] key_rd_reg;

    logic [7:0] perm_raddr, perm_waddr, perm_wdata;
    logic       perm_we, vld_clear, key_we;

    logic       in_accept, slot_free;
    logic [7:0] acc_mix, ks;
    logic [8:0] len_eff, pos_inc;
    logic [KEY_AW-1:0] pos_wrap;

    assign in_accept = in_valid && in_ready;
    // slot stays empty from here on: only this core loads the output register
    assign slot_free = !out_valid_reg || out_ready;
    assign perm_rd   = perm_rd_vld_reg ? perm_rd_mem_reg : perm_rd_addr_reg;
    assign acc_mix   = acc_reg + perm_rd + key_rd_reg;

    always_comb
    begin
        if (key_length_reg == 9'd0)
            len_eff = 9'd1;
        else if (key_length_reg > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = key_length_reg;
    end

    assign pos_inc  = 9'(pos_reg) + 9'd1;
    assign pos_wrap = (pos_inc >= len_eff) ? '0 : pos_inc[KEY_AW-1:0];

    // swap forwarding: j1 is written after the read of t was issued
    always_comb
    begin
        if (t_reg == j_reg)
            ks = si_reg;
        else if (t_reg == i_reg)
            ks = sj_reg;
        else
            ks = perm_rd;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_SCHED)
                        state_next = S_K_RD;
                    else if (mode == MODE_DATA)
                        state_next = S_D_J;
                end
            end
            S_D_J:
            begin
                if (slot_free)
                    state_next = S_D_T;
            end
            S_D_T:   state_next = S_D_OUT;
            S_D_OUT: state_next = S_IDLE;
            S_K_RD:  state_next = S_K_MIX;
            S_K_MIX: state_next = S_K_WA;
            S_K_WA:  state_next = S_K_WB;
            S_K_WB:  state_next = (n_reg == 8'hFF) ? S_IDLE : S_K_RD;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        perm_raddr = 8'd0;
        perm_we    = 1'b0;
        perm_waddr = 8'd0;
        perm_wdata = 8'd0;
        vld_clear  = 1'b0;
        key_we     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                perm_raddr = i_reg + 8'd1;
                key_we     = in_valid && (mode == MODE_KEY) &&
                             ({1'b0, key_index} < MAX_LEN);
                vld_clear  = in_valid && (mode == MODE_SCHED);
            end
            S_D_J:
            begin
                // while waiting, re-read S[i] to keep it on the read port
                perm_raddr = slot_free ? (j_reg + perm_rd) : i_reg;
            end
            S_D_T:
            begin
                perm_raddr = si_reg + perm_rd;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rd;
            end
            S_D_OUT:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
            end
            S_K_RD:
            begin
                perm_raddr = n_reg;
            end
            S_K_MIX:
            begin
                perm_raddr = acc_mix;
            end
            S_K_WA:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rd;
            end
            S_K_WB:
            begin
                perm_we    = 1'b1;
                perm_waddr = acc_reg;
                perm_wdata = si_reg;
            end
            default:
            begin
                perm_raddr = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        perm_rd_mem_reg  <= perm_mem[perm_raddr];
        perm_rd_vld_reg  <= perm_vld_reg[perm_raddr];
        perm_rd_addr_reg <= perm_raddr;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_index[KEY_AW-1:0]] <= key_byte;
        key_rd_reg <= key_mem[pos_reg];
    end

    // entry not valid reads as its own index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_vld_reg <= '0;
        else if (vld_clear)
            perm_vld_reg <= '0;
        else if (perm_we)
            perm_vld_reg[perm_waddr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= 8'd0;
            j_reg          <= 8'd0;
            n_reg          <= 8'd0;
            acc_reg        <= 8'd0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            key_length_reg <= KEY_LENGTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (key_length_we)
                key_length_reg <= key_length;
            if (state_reg == S_D_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (mode == MODE_DATA))
                        i_reg <= i_reg + 8'd1;
                    if (in_accept && (mode == MODE_SCHED))
                    begin
                        n_reg   <= 8'd0;
                        acc_reg <= 8'd0;
                        pos_reg <= '0;
                    end
                end
                S_D_J:
                begin
                    if (slot_free)
                        j_reg <= j_reg + perm_rd;
                end
                S_K_MIX:
                begin
                    acc_reg <= acc_mix;
                end
                S_K_WB:
                begin
                    n_reg   <= n_reg + 8'd1;
                    pos_reg <= pos_wrap;
                    if (n_reg == 8'hFF)
                    begin
                        i_reg <= 8'd0;
                        j_reg <= 8'd0;
                    end
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (mode == MODE_DATA))
        begin
            data_hold_reg <= data_byte;
            last_hold_reg <= last_in;
        end
        if ((state_reg == S_D_J) && slot_free)
            si_reg <= perm_rd;
        if (state_reg == S_K_MIX)
            si_reg <= perm_rd;
        if (state_reg == S_D_T)
        begin
            sj_reg <= perm_rd;
            t_reg  <= si_reg + perm_rd;
        end
        if (state_reg == S_D_OUT)
        begin
            data_out_reg <= data_hold_reg ^ ks;
            last_out_reg <= last_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign last_out  = last_out_reg;

    a_slot_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_OUT) |-> !out_valid_reg)
        else $error("output register busy when result is produced");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_OUT) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not loaded after swap");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_K_WB) && (n_reg == 8'hFF)) |=>
        ((i_reg == 8'd0) && (j_reg == 8'd0) && (state_reg == S_IDLE)))
        else $error("key schedule did not clear indices");

    a_sched_identity: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_K_RD) && (n_reg == 8'd0)) |-> (perm_vld_reg == '0))
        else $error("permutation not reset to identity at schedule start");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        perm_we |-> !in_ready)
        else $error("permutation written while accepting commands");

endmodule

// ----- dv/rc4_cipher_check.sv -----
`timescale 1ns / 1ps

module rc4_cipher_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] key_index,
    input  logic [7:0] key_byte,
    input  logic [7:0] data_byte,
    input  logic       last_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_out,
    input  logic       last_out,
    input  logic       key_length_we,
    input  logic [8:0] key_length,
    output int         mismatches,
    output int         outstanding
);
    import rc4_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    cipher_byte_t pending_cipher_q[$];

    logic [7:0] sbox [PERM_DEPTH];
    logic [7:0] key_mem [PERM_DEPTH];
    logic [7:0] ptr_i;
    logic [7:0] ptr_j;
    logic [8:0] key_len;
    int         err_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        cipher_byte_t got;
        cipher_byte_t want;
        logic [7:0]   acc;
        logic [7:0]   tmp;
        int           eff_len;
        int           pos;

        if (!rst_n)
        begin
            for (int n = 0; n < PERM_DEPTH; n++)
                sbox[n] = n[7:0];
            ptr_i = '0;
            ptr_j = '0;
            key_len = KEY_LENGTH_RESET;
            err_cnt = 0;
            pending_cipher_q.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (key_length_we)
                key_len = key_length;

            // check output first so a result is never matched against the command accepted alongside it
            if (out_valid && out_ready)
            begin
                got = '{data: data_out, last: last_out};
                if (pending_cipher_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result data_out %h last_out %b",
                                 $realtime, data_out, last_out);
                end
                else
                begin
                    want = pending_cipher_q.pop_front();
                    if (got != want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch data_out exp %h got %h, last_out exp %b got %b",
                                     $realtime, want.data, got.data, want.last, got.last);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                case (mode)
                    MODE_KEY:
                        key_mem[key_index] = key_byte;
                    MODE_SCHED:
                    begin
                        // zero acts as one, anything past the store saturates
                        if (key_len == 0)
                            eff_len = 1;
                        else if (key_len > PERM_DEPTH)
                            eff_len = PERM_DEPTH;
                        else
                            eff_len = key_len;
                        for (int n = 0; n < PERM_DEPTH; n++)
                            sbox[n] = n[7:0];
                        acc = '0;
                        pos = 0;
                        for (int n = 0; n < PERM_DEPTH; n++)
                        begin
                            acc = acc + sbox[n] + key_mem[pos];
                            tmp = sbox[n];
                            sbox[n] = sbox[acc];
                            sbox[acc] = tmp;
                            pos = (pos + 1 == eff_len) ? 0 : pos + 1;
                        end
                        ptr_i = '0;
                        ptr_j = '0;
                    end
                    MODE_DATA:
                    begin
                        ptr_i = ptr_i + 8'd1;
                        ptr_j = ptr_j + sbox[ptr_i];
                        tmp = sbox[ptr_i];
                        sbox[ptr_i] = sbox[ptr_j];
                        sbox[ptr_j] = tmp;
                        tmp = sbox[ptr_i] + sbox[ptr_j];
                        want = '{data: data_byte ^ sbox[tmp], last: last_in};
                        pending_cipher_q.push_back(want);
                    end
                    default:
                        ;
                endcase
            end

            mismatches <= err_cnt;
            outstanding <= pending_cipher_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rc4_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int ITEMS          = 700;
    localparam int NUM_PHASES     = 8;
    localparam int SCHED_CYCLES   = 1100;
    localparam int TAIL_CYCLES    = 64;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 8000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] mode = MODE_KEY;
    logic [7:0] key_index = '0;
    logic [7:0] key_byte = '0;
    logic [7:0] data_byte = '0;
    logic       last_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_out;
    logic       last_out;
    logic       key_length_we = 1'b0;
    logic [8:0] key_length = '0;

    int         mismatches;
    int         outstanding;
    int         sent = 0;
    int         stalled = 0;
    bit         key_written [PERM_DEPTH];
    bit         no_idle = 1'b0;
    bit         burst_on = 1'b0;
    logic [8:0] cur_len = KEY_LENGTH_RESET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rc4_stream_cipher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .key_index     (key_index),
        .key_byte      (key_byte),
        .data_byte     (data_byte),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_out      (data_out),
        .last_out      (last_out),
        .key_length_we (key_length_we),
        .key_length    (key_length)
    );

    rc4_cipher_check cipher_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .key_index     (key_index),
        .key_byte      (key_byte),
        .data_byte     (data_byte),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_out      (data_out),
        .last_out      (last_out),
        .key_length_we (key_length_we),
        .key_length    (key_length),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // one command transaction; valid is only dropped for an idle gap before it
    task automatic drive_cmd(input logic [1:0] m, input logic [7:0] ki, input logic [7:0] kb,
                             input logic [7:0] db, input logic lst);
        int gap;
        int r;

        r = $urandom_range(0, 99);
        if (no_idle || burst_on || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        key_index <= ki;
        key_byte <= kb;
        data_byte <= db;
        last_in <= lst;
        if (m == MODE_KEY)
            key_written[ki] = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_key_length(input logic [8:0] v);
        drain_results();
        // a key schedule may still be running with nothing left to return
        repeat (SCHED_CYCLES) @(posedge clk);
        key_length_we <= 1'b1;
        key_length <= v;
        @(posedge clk);
        key_length_we <= 1'b0;
        cur_len = v;
    endtask

    // result side: choppy, fully open or stalled stretches, plus one long hold
    initial
    begin : receiver
        int seg;
        bit hold_done;

        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            seg = $urandom_range(0, 9);
            if (!hold_done && burst_on && out_valid)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (seg < 3)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 120)) @(posedge clk);
            end
            else if (seg == 9)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 3) != 0);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stalled <= 0;
        else
        begin
            stalled <= stalled + 1;
            if (stalled >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int         dir_items;
        int         goal;
        int         eff;
        int         msg_len;
        bit         burst_done;
        logic [1:0] m;
        logic [8:0] new_len;

        burst_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data on the reset permutation, then a session at the reset key length
        drive_cmd(MODE_DATA, 8'hFF, 8'hFF, 8'h00, 1'b0);
        drive_cmd(MODE_DATA, 8'h00, 8'h00, 8'hFF, 1'b1);
        drive_cmd(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        for (int k = 0; k < 16; k++)
            drive_cmd(MODE_KEY, k[7:0], (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom),
                      8'($urandom), 1'($urandom));
        drive_cmd(MODE_KEY, 8'hFF, 8'hA5, 8'($urandom), 1'b0);
        drive_cmd(MODE_SCHED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        drive_cmd(MODE_DATA, 8'($urandom), 8'($urandom), 8'h00, 1'b0);
        drive_cmd(MODE_DATA, 8'($urandom), 8'($urandom), 8'hFF, 1'b1);
        drive_cmd(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        drive_cmd(MODE_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        dir_items = sent;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: new_len = 9'd1;
                1: new_len = 9'd0;
                2: new_len = 9'd5;
                3: new_len = 9'd256;
                4: new_len = 9'd3;
                5: new_len = 9'd511;
                6: new_len = 9'($urandom_range(2, 255));
                default: new_len = 9'd300;
            endcase
            set_key_length(new_len);
            no_idle = (p % 3 == 2);
            goal = dir_items + ITEMS * (p + 1) / NUM_PHASES;
            while (sent < goal)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    if (cur_len == 0)
                        eff = 1;
                    else if (cur_len > PERM_DEPTH)
                        eff = PERM_DEPTH;
                    else
                        eff = cur_len;
                    // the schedule must never read a key entry that was never written
                    for (int n = 0; n < eff; n++)
                        if (!key_written[n] || (eff <= 16 && $urandom_range(0, 1) == 1))
                            drive_cmd(MODE_KEY, n[7:0], 8'($urandom), 8'($urandom),
                                      1'($urandom));
                    if (eff > 16)
                        repeat ($urandom_range(0, 4))
                            drive_cmd(MODE_KEY, 8'($urandom_range(0, eff - 1)), 8'($urandom),
                                      8'($urandom), 1'($urandom));
                    drive_cmd(MODE_SCHED, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom));
                    msg_len = $urandom_range(1, 24);
                    if (!burst_done)
                    begin
                        msg_len = 48;
                        burst_on = 1'b1;
                        burst_done = 1'b1;
                    end
                    for (int k = 0; k < msg_len; k++)
                        drive_cmd(MODE_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                                  k == msg_len - 1);
                    burst_on = 1'b0;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: m = MODE_KEY;
                        1: m = MODE_DATA;
                        default: m = MODE_UNUSED;
                    endcase
                    drive_cmd(m, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
